>>> hdl/b2p_pkg.sv
// Shared constants, types and register codes of the bitmap to page converter.
package b2p_pkg;

    // Image limits and derived store geometry
    localparam int MAX_WIDTH     = 128;
    localparam int MAX_HEIGHT    = 64;
    localparam int BAND_ROWS     = 8;
    localparam int STORED_ROWS   = BAND_ROWS - 1;
    localparam int MAX_BYTE_COLS = (MAX_WIDTH + 7) / 8;

    // Field and counter widths
    localparam int WIDTH_W  = 8;
    localparam int HEIGHT_W = 7;
    localparam int COL_W    = 4;
    localparam int ROW_W    = 6;
    localparam int PAGE_W   = 3;
    localparam int VCOL_W   = 4;
    localparam int BW_W     = COL_W + 1;
    localparam int PAGES_W  = HEIGHT_W - 3;

    // Register reset values
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 8'd128;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 7'd64;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    // Block queue geometry
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // One completed 8x8 block on its way to the transpose
    typedef struct packed {
        logic [BAND_ROWS-1:0][7:0] rows;
        logic [PAGE_W-1:0]         page;
        logic [COL_W-1:0]          blk;
        logic [VCOL_W-1:0]         vcols;
        logic                      last;
    } t_blk;

endpackage

>>> hdl/b2p_ram.sv
// Generic single-write, single-read RAM with registered read data.
module b2p_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/b2p_front.sv
// Front end: config registers, row/column counters, band store and block issue.
module b2p_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [b2p_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [b2p_pkg::WIDTH_W-1:0]       i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [7:0]                        i_pixel_byte,
    input  logic [b2p_pkg::Q_CNT_W-1:0]       i_q_level,
    output logic                              o_push,
    output b2p_pkg::t_blk                     o_push_blk
);

    localparam int SR = b2p_pkg::STORED_ROWS;

    logic [b2p_pkg::WIDTH_W-1:0]  r_width;
    logic [b2p_pkg::HEIGHT_W-1:0] r_height;
    logic [b2p_pkg::COL_W-1:0]    r_col, n_col;
    logic [b2p_pkg::ROW_W-1:0]    r_row, n_row;

    logic [b2p_pkg::WIDTH_W-1:0]  w_eff;
    logic [b2p_pkg::HEIGHT_W-1:0] h_eff;
    logic [b2p_pkg::BW_W-1:0]     bw;
    logic [b2p_pkg::PAGES_W-1:0]  pages;
    logic [b2p_pkg::HEIGHT_W-1:0] band_lim;
    logic [b2p_pkg::WIDTH_W-1:0]  col_left;
    logic [b2p_pkg::VCOL_W-1:0]   vcols;
    logic                         in_img;
    logic                         emit;
    logic                         accept;
    logic                         last;

    logic                         r_s1_valid;
    logic [7:0]                   r_s1_px;
    logic [b2p_pkg::PAGE_W-1:0]   r_s1_page;
    logic [b2p_pkg::COL_W-1:0]    r_s1_blk;
    logic [b2p_pkg::VCOL_W-1:0]   r_s1_vcols;
    logic                         r_s1_last;

    logic [SR-1:0][7:0]           ram_rdata;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= b2p_pkg::WIDTH_RESET;
            r_height <= b2p_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                b2p_pkg::CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                b2p_pkg::CFG_IMAGE_HEIGHT: r_height <= i_cfg_data[b2p_pkg::HEIGHT_W-1:0];
                default:                   r_width  <= r_width;
            endcase
        end
    end

    // Clamp geometry and classify the current word
    always_comb begin
        if (r_width == '0) begin
            w_eff = b2p_pkg::WIDTH_W'(1);
        end else if (r_width > b2p_pkg::WIDTH_W'(b2p_pkg::MAX_WIDTH)) begin
            w_eff = b2p_pkg::WIDTH_W'(b2p_pkg::MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        if (r_height == '0) begin
            h_eff = b2p_pkg::HEIGHT_W'(1);
        end else if (r_height > b2p_pkg::HEIGHT_W'(b2p_pkg::MAX_HEIGHT)) begin
            h_eff = b2p_pkg::HEIGHT_W'(b2p_pkg::MAX_HEIGHT);
        end else begin
            h_eff = r_height;
        end
        bw       = b2p_pkg::BW_W'(({1'b0, w_eff} + 9'd7) >> 3);
        pages    = b2p_pkg::PAGES_W'(h_eff >> 3);
        band_lim = {pages, 3'b000};
        in_img   = ({1'b0, r_col} < bw) && ({1'b0, r_row} < band_lim);
        emit     = in_img && (r_row[2:0] == 3'(SR));
        col_left = w_eff - {1'b0, r_col, 3'b000};
        vcols    = (col_left > 8'd8) ? 4'd8 : col_left[b2p_pkg::VCOL_W-1:0];
        last     = ({1'b0, r_row[5:3]} == (pages - 4'd1))
                && ({1'b0, r_col} == (bw - 5'd1));
    end

    // Leave room in the queue for the block in flight
    assign o_in_ready = (4'(i_q_level) + 4'(r_s1_valid)) < 4'(b2p_pkg::Q_DEPTH);
    assign accept     = i_in_valid && o_in_ready;

    // Advance counters, wrap at row and image end
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (({1'b0, r_col} + 5'd1) >= bw) begin
                n_col = '0;
                n_row = (({1'b0, r_row} + 7'd1) >= h_eff) ? '0 : r_row + 6'd1;
            end else begin
                n_col = r_col + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Band store: one RAM per stored band row, addressed by byte column
    for (genvar b = 0; b < SR; b++) begin : g_band
        b2p_ram #(
            .WIDTH (8),
            .DEPTH (b2p_pkg::MAX_BYTE_COLS)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (accept && in_img && (r_row[2:0] == 3'(b))),
            .i_waddr (r_col),
            .i_wdata (i_pixel_byte),
            .i_re    (accept && emit),
            .i_raddr (r_col),
            .o_rdata (ram_rdata[b])
        );
    end

    // Hold block fields while the band rows are read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_s1_px    <= i_pixel_byte;
            r_s1_page  <= r_row[5:3];
            r_s1_blk   <= r_col;
            r_s1_vcols <= vcols;
            r_s1_last  <= last;
        end
    end

    // Push the completed block
    always_comb begin
        o_push_blk.rows[SR-1:0] = ram_rdata;
        o_push_blk.rows[SR]     = r_s1_px;
        o_push_blk.page         = r_s1_page;
        o_push_blk.blk          = r_s1_blk;
        o_push_blk.vcols        = r_s1_vcols;
        o_push_blk.last         = r_s1_last;
    end

    assign o_push = r_s1_valid;

endmodule

>>> hdl/b2p_queue.sv
// Short block queue between front end and transpose stage.
module b2p_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  b2p_pkg::t_blk               i_push_blk,
    input  logic                        i_pop,
    output logic                        o_vld,
    output b2p_pkg::t_blk               o_blk,
    output logic [b2p_pkg::Q_CNT_W-1:0] o_level
);

    b2p_pkg::t_blk               r_mem [b2p_pkg::Q_DEPTH];
    logic [b2p_pkg::Q_PTR_W-1:0] r_wptr;
    logic [b2p_pkg::Q_PTR_W-1:0] r_rptr;
    logic [b2p_pkg::Q_CNT_W-1:0] r_cnt;
    logic                        do_pop;

    assign o_vld   = (r_cnt != '0);
    assign o_blk   = r_mem[r_rptr];
    assign o_level = r_cnt;
    assign do_pop  = i_pop && o_vld;

    // Store pushed blocks
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_blk;
        end
    end

    // Advance pointers and level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 2'd1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 2'd1;
            end
            case ({i_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 3'd1;
                2'b01:   r_cnt <= r_cnt - 3'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> hdl/b2p_back.sv
// Back end: transpose one block into column bytes and hold it on the output.
module b2p_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_vld,
    input  b2p_pkg::t_blk                i_q_blk,
    output logic                         o_pop,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [63:0]                  o_block_columns,
    output logic [b2p_pkg::PAGE_W-1:0]   o_page_index,
    output logic [b2p_pkg::COL_W-1:0]    o_block_index,
    output logic [b2p_pkg::VCOL_W-1:0]   o_valid_columns,
    output logic                         o_last_block
);

    logic                       r_valid;
    logic [63:0]                r_cols;
    logic [b2p_pkg::PAGE_W-1:0] r_page;
    logic [b2p_pkg::COL_W-1:0]  r_blk;
    logic [b2p_pkg::VCOL_W-1:0] r_vcols;
    logic                       r_last;
    logic [63:0]                cols;

    // Transpose: column k, bit b is row b pixel k; zero columns past the edge
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            for (int b = 0; b < b2p_pkg::BAND_ROWS; b++) begin
                cols[8*k + b] = (4'(k) < i_q_blk.vcols) ? i_q_blk.rows[b][7-k] : 1'b0;
            end
        end
    end

    assign o_pop = i_q_vld && (!r_valid || i_out_ready);

    // Load output register when it is free or being taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || i_out_ready) begin
            r_valid <= i_q_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cols  <= cols;
            r_page  <= i_q_blk.page;
            r_blk   <= i_q_blk.blk;
            r_vcols <= i_q_blk.vcols;
            r_last  <= i_q_blk.last;
        end
    end

    assign o_out_valid     = r_valid;
    assign o_block_columns = r_cols;
    assign o_page_index    = r_page;
    assign o_block_index   = r_blk;
    assign o_valid_columns = r_vcols;
    assign o_last_block    = r_last;

endmodule

>>> hdl/bitmap_to_page_converter_core.sv
// Top level of the bitmap to page converter: front end, block queue, transpose stage.
//
//  channel   direction  handshake                    payload
//  input     in         i_in_valid / o_in_ready      i_pixel_byte
//  output    out        o_out_valid / i_out_ready    o_block_columns, o_page_index,
//                                                    o_block_index, o_valid_columns,
//                                                    o_last_block
//  config    in         i_cfg_we (no wait)           i_cfg_index, i_cfg_data
//
// One pixel word is taken per cycle while o_in_ready is high; a block that a word completes
// passes the band-store read, queue and output registers before it is offered.
// Throughput is set by the single band-store access per word: one word per cycle while ready.
// Reset is synchronous and active low; it clears counters, queue and output valid.
// A stalled output fills the four-entry queue, then o_in_ready drops.
module bitmap_to_page_converter_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [b2p_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [b2p_pkg::WIDTH_W-1:0]       i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [7:0]                        i_pixel_byte,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [63:0]                       o_block_columns,
    output logic [b2p_pkg::PAGE_W-1:0]        o_page_index,
    output logic [b2p_pkg::COL_W-1:0]         o_block_index,
    output logic [b2p_pkg::VCOL_W-1:0]        o_valid_columns,
    output logic                              o_last_block
);

    logic                        push;
    b2p_pkg::t_blk               push_blk;
    logic                        pop;
    logic                        q_vld;
    b2p_pkg::t_blk               q_blk;
    logic [b2p_pkg::Q_CNT_W-1:0] q_level;

    b2p_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_pixel_byte (i_pixel_byte),
        .i_q_level    (q_level),
        .o_push       (push),
        .o_push_blk   (push_blk)
    );

    b2p_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_blk (push_blk),
        .i_pop      (pop),
        .o_vld      (q_vld),
        .o_blk      (q_blk),
        .o_level    (q_level)
    );

    b2p_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_vld         (q_vld),
        .i_q_blk         (q_blk),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_block_columns (o_block_columns),
        .o_page_index    (o_page_index),
        .o_block_index   (o_block_index),
        .o_valid_columns (o_valid_columns),
        .o_last_block    (o_last_block)
    );

endmodule

>>> hdl/b2p_checker.sv
// Port-level checks of the converter and their binding to the top level.
module b2p_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              o_out_valid,
    input  logic                              i_out_ready,
    input  logic [63:0]                       o_block_columns,
    input  logic [b2p_pkg::VCOL_W-1:0]        o_valid_columns
);

    // Reset empties the output
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word valid after reset");

    // A stalled word stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("output word dropped while stalled");

    // Column count is always one to eight
    a_vcols_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_valid_columns != 4'd0 && o_valid_columns <= 4'd8))
        else $error("valid column count out of range");

    // Columns past the right edge are zero
    a_edge_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_valid_columns < 4'd8)
        |-> ((o_block_columns >> {o_valid_columns, 3'b000}) == 64'd0))
        else $error("nonzero column past the image edge");

endmodule

bind bitmap_to_page_converter_core b2p_checker u_b2p_checker (.*);

>>> test/b2p_block_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the bitmap to page converter: predicts block words and compares them.
module b2p_block_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [b2p_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [b2p_pkg::WIDTH_W-1:0]   i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [7:0]                    i_pixel_byte,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [63:0]                   i_block_columns,
    input  logic [b2p_pkg::PAGE_W-1:0]    i_page_index,
    input  logic [b2p_pkg::COL_W-1:0]     i_block_index,
    input  logic [b2p_pkg::VCOL_W-1:0]    i_valid_columns,
    input  logic                          i_last_block,
    output int                            o_fail_count,
    output int                            o_pending,
    output logic                          o_at_image_start
);
    import b2p_pkg::*;

    // One expected block word
    typedef struct packed {
        logic [63:0]       columns;
        logic [PAGE_W-1:0] page;
        logic [COL_W-1:0]  blk;
        logic [VCOL_W-1:0] vcols;
        logic              last;
    } t_block_word;

    t_block_word         expected_blocks[$];
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [7:0]          band_rows [STORED_ROWS][MAX_BYTE_COLS];
    int unsigned         row_pos;
    int unsigned         col_pos;
    int                  mismatches = 0;

    // Store one pixel word of the band, or transpose the 8x8 block that it completes
    task automatic transpose_word(input logic [7:0] px);
        int unsigned  w;
        int unsigned  h;
        int unsigned  bw;
        int unsigned  pages;
        int unsigned  brow;
        int unsigned  vcols;
        logic [7:0]   rows [BAND_ROWS];
        t_block_word  blk;
        w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
        h = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
        bw = (w + 7) / 8;
        pages = h / BAND_ROWS;
        if (row_pos < h && col_pos < bw && col_pos < MAX_BYTE_COLS &&
            row_pos < pages * BAND_ROWS) begin
            brow = row_pos % BAND_ROWS;
            if (brow < STORED_ROWS) begin
                band_rows[brow][col_pos] = px;
            end else begin
                vcols = w - 8 * col_pos;
                if (vcols > 8) vcols = 8;
                for (int b = 0; b < STORED_ROWS; b++) rows[b] = band_rows[b][col_pos];
                rows[BAND_ROWS-1] = px;
                // column k of the block takes bit 7-k of every band row
                blk.columns = '0;
                for (int k = 0; k < vcols; k++)
                    for (int b = 0; b < BAND_ROWS; b++)
                        blk.columns[8*k+b] = rows[b][7-k];
                blk.page  = PAGE_W'(row_pos / BAND_ROWS);
                blk.blk   = COL_W'(col_pos);
                blk.vcols = VCOL_W'(vcols);
                blk.last  = (row_pos / BAND_ROWS == pages - 1) && (col_pos == bw - 1);
                expected_blocks.push_back(blk);
            end
        end
        // advance the position, wrapping at the end of a row and of the image
        if (col_pos + 1 >= bw) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_block_word want;
        if (!i_rst_n) begin
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            row_pos    = 0;
            col_pos    = 0;
            for (int r = 0; r < STORED_ROWS; r++)
                for (int c = 0; c < MAX_BYTE_COLS; c++) band_rows[r][c] = 8'h00;
            expected_blocks.delete();
        end else begin
            // track register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH:  width_reg = i_cfg_data;
                    CFG_IMAGE_HEIGHT: height_reg = i_cfg_data[HEIGHT_W-1:0];
                endcase
            end
            // compare each delivered block word with the oldest expectation
            if (i_out_valid && i_out_ready) begin
                if (expected_blocks.size() == 0) begin
                    $error("unexpected block word: columns %h page %0d block %0d",
                           i_block_columns, i_page_index, i_block_index);
                    mismatches++;
                end else begin
                    want = expected_blocks.pop_front();
                    if (i_block_columns !== want.columns) begin
                        $error("block_columns: expected %h, actual %h",
                               want.columns, i_block_columns);
                        mismatches++;
                    end
                    if (i_page_index !== want.page) begin
                        $error("page_index: expected %0d, actual %0d", want.page, i_page_index);
                        mismatches++;
                    end
                    if (i_block_index !== want.blk) begin
                        $error("block_index: expected %0d, actual %0d", want.blk, i_block_index);
                        mismatches++;
                    end
                    if (i_valid_columns !== want.vcols) begin
                        $error("valid_columns: expected %0d, actual %0d",
                               want.vcols, i_valid_columns);
                        mismatches++;
                    end
                    if (i_last_block !== want.last) begin
                        $error("last_block: expected %0b, actual %0b", want.last, i_last_block);
                        mismatches++;
                    end
                end
            end
            // predict from each accepted pixel word
            if (i_in_valid && i_in_ready) transpose_word(i_pixel_byte);
        end
        o_fail_count     <= mismatches;
        o_pending        <= expected_blocks.size();
        o_at_image_start <= (row_pos == 0) && (col_pos == 0);
    end

endmodule

>>> test/tb_bitmap_to_page_converter_core.sv
`timescale 1ns / 1ps
// Testbench top for the bitmap to page converter: stimulus, flow control and verdict.
module tb_bitmap_to_page_converter_core;
    import b2p_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WIDTH_W-1:0]   cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [7:0]           pixel_byte;
    logic                 out_valid;
    logic                 out_ready;
    logic [63:0]          block_columns;
    logic [PAGE_W-1:0]    page_index;
    logic [COL_W-1:0]     block_index;
    logic [VCOL_W-1:0]    valid_columns;
    logic                 last_block;

    int          fail_count;
    int          pending;
    logic        at_image_start;
    bit          calm = 1'b0;
    int unsigned word_count = 0;

    // Hand-picked words: a one-pixel-wide image, then a 12x9 image with a ragged right edge
    logic [7:0] corner_words [26] = '{
        8'h80, 8'h00, 8'h80, 8'h7F, 8'hFF, 8'h00, 8'h80, 8'h01,
        8'hFF, 8'hFF, 8'h00, 8'h0F, 8'hAA, 8'h5A, 8'h55, 8'hA5, 8'h01, 8'h3C,
        8'h80, 8'hC3, 8'hFF, 8'hFF, 8'h00, 8'h0F, 8'h5A, 8'hC3
    };

    always #6 clk = ~clk;

    bitmap_to_page_converter_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_pixel_byte    (pixel_byte),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_block_columns (block_columns),
        .o_page_index    (page_index),
        .o_block_index   (block_index),
        .o_valid_columns (valid_columns),
        .o_last_block    (last_block)
    );

    b2p_block_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_pixel_byte     (pixel_byte),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_block_columns  (block_columns),
        .i_page_index     (page_index),
        .i_block_index    (block_index),
        .i_valid_columns  (valid_columns),
        .i_last_block     (last_block),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_at_image_start (at_image_start)
    );

    // Random pixel word, leaning on all-dark and all-lit bytes
    function automatic logic [7:0] pixel_word();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Clamp a register value the way the block reads it
    function automatic int unsigned span(input int unsigned v, input int unsigned ceiling);
        return (v == 0) ? 1 : (v > ceiling) ? ceiling : v;
    endfunction

    // Offer one word after a random gap; return at the edge that takes it
    task automatic send_word(input logic [7:0] px);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        pixel_byte <= px;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        word_count++;
    endtask

    // Drain the block, let in-flight words settle, then write both registers
    task automatic set_image(input logic [7:0] w_data, input logic [7:0] h_data);
        do @(posedge clk); while (pending != 0);
        repeat (8) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IMAGE_WIDTH;
        cfg_data  <= w_data;
        @(posedge clk);
        cfg_index <= CFG_IMAGE_HEIGHT;
        cfg_data  <= h_data;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Feed single words until the block's position is back at the image origin
    task automatic realign();
        while (!at_image_start) begin
            send_word(pixel_word());
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Configure and stream one image; a cut image stops partway through
    task automatic send_image(input logic [7:0] w_data, input int unsigned h, input bit cut);
        int unsigned w_eff;
        int unsigned h_eff;
        int unsigned bw;
        int unsigned total;
        int unsigned count;
        set_image(w_data, {1'($urandom_range(0, 1)), 7'(h)});
        w_eff = span(w_data, MAX_WIDTH);
        h_eff = span(h & 7'h7F, MAX_HEIGHT);
        bw    = (w_eff + 7) / 8;
        total = bw * h_eff;
        count = (cut && total > 1) ? $urandom_range(1, total - 1) : total;
        for (int i = 0; i < count; i++) send_word(pixel_word());
        in_valid <= 1'b0;
    endtask

    // Output side: hold ready low for a random stall before each block word
    initial begin : drain_side
        int stall;
        out_ready <= 1'b0;
        @(posedge clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 4);
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial begin : stimulus
        int waited;
        int unsigned sel;
        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_index  <= CFG_IMAGE_WIDTH;
        cfg_data   <= '0;
        in_valid   <= 1'b0;
        pixel_byte <= 8'h00;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full-width band at reset settings; this also fills every band-store entry
        for (int i = 0; i < MAX_WIDTH; i++) send_word(pixel_word());
        in_valid <= 1'b0;

        // Shrink the height below the current row: stale position words are dropped
        set_image(8'd128, 8'd4);
        realign();

        // One-pixel-wide image, then a 12x9 image with its ninth row dropped
        set_image(8'd1, 8'd8);
        for (int i = 0; i < 8; i++) send_word(corner_words[i]);
        in_valid <= 1'b0;
        set_image(8'd12, 8'd9);
        for (int i = 8; i < 26; i++) send_word(corner_words[i]);
        in_valid <= 1'b0;

        // Zero width and height: a 1x1 image with no full band, every word dropped
        set_image(8'd0, 8'd0);
        send_word(8'hFF);
        send_word(8'h00);
        in_valid <= 1'b0;

        // Random images, mostly well formed, some clamped and some cut short
        while (word_count < 850) begin
            calm = ($urandom_range(0, 3) == 0);
            sel  = $urandom_range(0, 9);
            if (sel == 0) begin
                case ($urandom_range(0, 3))
                    0: send_image(8'($urandom_range(128, 255)), 8, 1'b0);
                    1: send_image(8'($urandom_range(1, 16)), $urandom_range(64, 127), 1'b0);
                    2: send_image(8'd0, $urandom_range(0, 16), 1'b0);
                    default: send_image(8'($urandom_range(1, 40)), 0, 1'b0);
                endcase
            end else if (sel == 9) begin
                send_image(8'($urandom_range(1, 48)), $urandom_range(1, 24), 1'b1);
                set_image(8'($urandom_range(1, 32)), {1'($urandom_range(0, 1)),
                          7'($urandom_range(1, 16))});
                realign();
            end else begin
                send_image(8'($urandom_range(1, 48)),
                           ($urandom_range(0, 5) == 0) ? $urandom_range(1, 7)
                                                       : $urandom_range(8, 24), 1'b0);
            end
        end
        calm = 1'b0;

        // Wait for the last block words, then watch a little longer for strays
        waited = 0;
        while (pending != 0 && waited < 4000) begin
            @(posedge clk);
            waited++;
        end
        repeat (16) @(posedge clk);
        if (pending != 0) $error("%0d block word(s) never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("bitmap_to_page_converter_core verification clean");
        end else begin
            $display("bitmap_to_page_converter_core verification failed");
        end
        $finish;
    end

    // Hard stop if the run hangs
    initial begin : watchdog
        #5_000_000;
        $display("bitmap_to_page_converter_core verification failed");
        $finish;
    end

endmodule

>>> files.f
hdl/b2p_pkg.sv
hdl/b2p_ram.sv
hdl/b2p_front.sv
hdl/b2p_queue.sv
hdl/b2p_back.sv
hdl/bitmap_to_page_converter_core.sv
hdl/b2p_checker.sv
test/b2p_block_checker.sv
test/tb_bitmap_to_page_converter_core.sv
